[rtl/crc_framed_record_checker_defines.svh]
// Assertion macros used by the record checker core.
`ifndef CRC_FRAMED_RECORD_CHECKER_DEFINES_SVH
`define CRC_FRAMED_RECORD_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define CFRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfrc assertion failed");

// Next-cycle implication, disabled while reset is active.
`define CFRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfrc assertion failed");

`endif

[rtl/cfrc_pkg.sv]
// Types, constants and the CRC-32 byte update for the record checker.
`timescale 1ns / 1ps
`default_nettype none
package cfrc_pkg;

    localparam int unsigned NUM_FIELDS = 8;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;
    localparam logic [31:0] MAGIC_WORD   = 32'h4D505841;
    localparam logic [15:0] VERSION_NEW  = 16'd2;
    localparam logic [15:0] VERSION_OLD  = 16'd1;
    localparam logic [31:0] HDR_BYTES    = 32'd24;
    localparam logic [31:0] HDR_CRC_LAST = 32'd19;
    localparam logic [31:0] PAY_HDR_V2   = 32'd24;
    localparam logic [31:0] PAY_HDR_V1   = 32'd16;
    localparam logic [15:0] LIMIT_RESET  = 16'd256;
    localparam logic [31:0] COUNT_MAX    = 32'hFFFFFFFF;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_SHORT    = 4'd1;
    localparam logic [3:0] ST_MAGIC    = 4'd2;
    localparam logic [3:0] ST_HDRSIZE  = 4'd3;
    localparam logic [3:0] ST_HDRCRC   = 4'd4;
    localparam logic [3:0] ST_VERSION  = 4'd5;
    localparam logic [3:0] ST_PAYSIZE  = 4'd6;
    localparam logic [3:0] ST_PAYCRC   = 4'd7;
    localparam logic [3:0] ST_LENGTHS  = 4'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic        in_field;
        logic [2:0]  field_index;
        logic        done_res;
        logic [3:0]  status;
        logic [31:0] record_generation;
        logic [63:0] expires_at;
    } t_out_item;

    // Reflected CRC-32, one byte.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[rtl/crc_framed_record_checker.sv]
// Top level of the streaming CRC-framed record checker.
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_ready    i_data (data_byte, last_byte)
//   result    out        o_valid / i_ready    o_data (byte_out ... expires_at)
//   config    in         i_cfg_we             i_cfg_idx, i_cfg_data (field limits)
//
// One item a cycle sustained while the sink takes results; each result is presented
// once its item has passed the input queue and then the core's output register, which
// the byte-wide CRC-32 update and the checks of the core stage feed combinationally.
// A two-entry queue feeds the core; the core's output register holds a result while
// the sink stalls, and the queue keeps taking items until it fills.
// Reset (i_rst_n low, synchronous) empties the queue, drops any pending result,
// sets every limit to 256 and clears the record state.
`timescale 1ns / 1ps
`default_nettype none
module crc_framed_record_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire cfrc_pkg::t_in_item i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output cfrc_pkg::t_out_item     o_data,
    input  wire logic               i_cfg_we,
    input  wire logic [3:0]         i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data
);
    logic               w_q_valid, w_q_ready;
    cfrc_pkg::t_in_item w_q_data;

    // hold incoming items until the core takes them
    cfrc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .o_q_valid (w_q_valid),
        .i_q_ready (w_q_ready),
        .o_q_data  (w_q_data)
    );

    // parse, tag and check each byte; report on the last one
    cfrc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .o_q_ready  (w_q_ready),
        .i_q_data   (w_q_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );
endmodule
`default_nettype wire

[rtl/cfrc_front.sv]
// Input side: accepts items into a two-entry queue ahead of the checker core.
`timescale 1ns / 1ps
`default_nettype none
module cfrc_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire cfrc_pkg::t_in_item i_data,
    output logic                   o_q_valid,
    input  wire logic              i_q_ready,
    output cfrc_pkg::t_in_item     o_q_data
);
    cfrc_pkg::t_in_item r_mem [cfrc_pkg::QUEUE_DEPTH];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push, w_pop;

    assign o_ready   = (r_count != 2'(cfrc_pkg::QUEUE_DEPTH));
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_data  = r_mem[r_rd_ptr];
    assign w_push    = i_valid && o_ready;
    assign w_pop     = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule
`default_nettype wire

[rtl/cfrc_back.sv]
// Checker core: parses the record, tags field bytes, reports status on the last byte.
`timescale 1ns / 1ps
`default_nettype none
`include "crc_framed_record_checker_defines.svh"
module cfrc_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    output logic                    o_q_ready,
    input  wire cfrc_pkg::t_in_item i_q_data,
    input  wire logic               i_cfg_we,
    input  wire logic [3:0]         i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output cfrc_pkg::t_out_item     o_data
);
    logic [15:0] r_limit [cfrc_pkg::NUM_FIELDS];

    logic [31:0] r_cnt, r_crc, r_hcalc, r_gen, r_psz, r_pcrc, r_hcrc, r_pcalc;
    logic        r_magic_ok;
    logic [15:0] r_ver, r_hsz;
    logic [63:0] r_exp;
    logic [15:0] r_len [cfrc_pkg::NUM_FIELDS];
    logic [18:0] r_cum [cfrc_pkg::NUM_FIELDS];

    logic [31:0] n_cnt, n_crc, n_hcalc, n_gen, n_psz, n_pcrc, n_hcrc, n_pcalc;
    logic        n_magic_ok;
    logic [15:0] n_ver, n_hsz;
    logic [63:0] n_exp;
    logic [15:0] n_len [cfrc_pkg::NUM_FIELDS];
    logic [18:0] n_cum [cfrc_pkg::NUM_FIELDS];

    cfrc_pkg::t_out_item r_out, n_out;
    logic        r_out_valid;
    logic        w_take;

    logic [31:0] w_crc_step, w_p, w_q, w_phs, w_fphs, w_bc;
    logic [2:0]  w_fi;
    logic [15:0] w_full;
    logic [18:0] w_base, w_sum;
    logic [7:0]  w_b, w_magic_b;
    logic [3:0]  w_status;
    logic        w_len_bad;

    assign w_take    = i_q_valid && (!r_out_valid || i_ready);
    assign o_q_ready = !r_out_valid || i_ready;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;

    always_comb begin
        w_b        = i_q_data.data_byte;
        w_crc_step = cfrc_pkg::crc_byte(r_crc, w_b);
        w_magic_b  = 8'(cfrc_pkg::MAGIC_WORD >> (5'd24 - {r_cnt[1:0], 3'd0}));
        w_p        = r_cnt - cfrc_pkg::HDR_BYTES;
        w_phs      = (r_ver == cfrc_pkg::VERSION_OLD) ? cfrc_pkg::PAY_HDR_V1
                                                      : cfrc_pkg::PAY_HDR_V2;
        w_q        = w_p - w_phs;
        w_fi       = 3'(w_p[4:1] - 4'd4);
        w_full     = {r_len[w_fi][7:0], w_b};
        w_base     = (w_fi == 3'd0) ? 19'd0 : r_cum[w_fi - 3'd1];
        w_sum      = w_base + 19'(w_full);

        n_cnt = r_cnt;  n_crc = r_crc;  n_hcalc = r_hcalc;  n_gen = r_gen;
        n_psz = r_psz;  n_pcrc = r_pcrc; n_hcrc = r_hcrc;   n_pcalc = r_pcalc;
        n_magic_ok = r_magic_ok; n_ver = r_ver; n_hsz = r_hsz; n_exp = r_exp;
        n_len = r_len;
        n_cum = r_cum;
        n_out = '0;
        n_out.byte_out = w_b;
        n_out.done_res = i_q_data.last_byte;

        if (r_cnt != cfrc_pkg::COUNT_MAX) begin
            if (r_cnt < 32'd4) begin
                if (w_b != w_magic_b) n_magic_ok = 1'b0;
            end else if (r_cnt < 32'd6) begin
                n_ver = {r_ver[7:0], w_b};
            end else if (r_cnt < 32'd8) begin
                n_hsz = {r_hsz[7:0], w_b};
            end else if (r_cnt < 32'd12) begin
                n_gen = {r_gen[23:0], w_b};
            end else if (r_cnt < 32'd16) begin
                n_psz = {r_psz[23:0], w_b};
            end else if (r_cnt < 32'd20) begin
                n_pcrc = {r_pcrc[23:0], w_b};
            end else if (r_cnt < cfrc_pkg::HDR_BYTES) begin
                n_hcrc = {r_hcrc[23:0], w_b};
            end

            if (r_cnt <= cfrc_pkg::HDR_CRC_LAST) begin
                n_crc = w_crc_step;
                if (r_cnt == cfrc_pkg::HDR_CRC_LAST) begin
                    n_hcalc = ~w_crc_step;
                    n_crc   = cfrc_pkg::CRC_INIT;
                    n_pcalc = '0;
                end
            end else if (r_cnt >= cfrc_pkg::HDR_BYTES) begin
                if (w_p < r_psz) begin
                    n_crc   = w_crc_step;
                    n_pcalc = ~w_crc_step;
                end
                if (w_p < 32'd8) begin
                    n_exp = {r_exp[55:0], w_b};
                end else if (w_p < cfrc_pkg::PAY_HDR_V2) begin
                    if (r_ver != cfrc_pkg::VERSION_OLD || w_fi < 3'd4) begin
                        n_len[w_fi] = w_full;
                        // second byte closes the length: refresh this and later bounds
                        if (w_p[0]) begin
                            for (int j = 0; j < cfrc_pkg::NUM_FIELDS; j++) begin
                                if (3'(j) >= w_fi) n_cum[j] = w_sum;
                            end
                        end
                    end
                end
                if (w_p >= w_phs && w_p < r_psz) begin
                    for (int i = cfrc_pkg::NUM_FIELDS - 1; i >= 0; i--) begin
                        if (w_q < {13'd0, r_cum[i]}) begin
                            n_out.in_field    = 1'b1;
                            n_out.field_index = 3'(i);
                        end
                    end
                end
            end
            n_cnt = r_cnt + 32'd1;
        end

        // final checks on the post-update state
        w_bc   = n_cnt;
        w_fphs = (n_ver == cfrc_pkg::VERSION_OLD) ? cfrc_pkg::PAY_HDR_V1
                                                  : cfrc_pkg::PAY_HDR_V2;
        w_len_bad = (n_len[0] == 16'd0) || (n_len[1] == 16'd0) ||
                    ({13'd0, n_cum[7]} != (n_psz - w_fphs));
        for (int i = 0; i < cfrc_pkg::NUM_FIELDS; i++) begin
            if (n_len[i] >= r_limit[i]) w_len_bad = 1'b1;
        end
        if (w_bc < cfrc_pkg::HDR_BYTES)                 w_status = cfrc_pkg::ST_SHORT;
        else if (!n_magic_ok)                           w_status = cfrc_pkg::ST_MAGIC;
        else if (n_hsz != 16'(cfrc_pkg::HDR_BYTES))     w_status = cfrc_pkg::ST_HDRSIZE;
        else if (n_hcalc != n_hcrc)                     w_status = cfrc_pkg::ST_HDRCRC;
        else if (n_ver != cfrc_pkg::VERSION_NEW && n_ver != cfrc_pkg::VERSION_OLD)
                                                        w_status = cfrc_pkg::ST_VERSION;
        else if (n_psz < w_fphs || n_psz > (w_bc - cfrc_pkg::HDR_BYTES))
                                                        w_status = cfrc_pkg::ST_PAYSIZE;
        else if (n_pcalc != n_pcrc)                     w_status = cfrc_pkg::ST_PAYCRC;
        else if (w_len_bad)                             w_status = cfrc_pkg::ST_LENGTHS;
        else                                            w_status = cfrc_pkg::ST_OK;

        if (i_q_data.last_byte) begin
            n_out.status            = w_status;
            n_out.record_generation = n_gen;
            n_out.expires_at        = n_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cfrc_pkg::NUM_FIELDS; i++) r_limit[i] <= cfrc_pkg::LIMIT_RESET;
        end else if (i_cfg_we && i_cfg_idx < 4'(cfrc_pkg::NUM_FIELDS)) begin
            r_limit[i_cfg_idx[2:0]] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_take && i_q_data.last_byte)) begin
            r_cnt <= '0; r_crc <= cfrc_pkg::CRC_INIT; r_hcalc <= '0; r_gen <= '0;
            r_psz <= '0; r_pcrc <= '0; r_hcrc <= '0; r_pcalc <= '0;
            r_magic_ok <= 1'b1; r_ver <= '0; r_hsz <= '0; r_exp <= '0;
            for (int i = 0; i < cfrc_pkg::NUM_FIELDS; i++) begin
                r_len[i] <= '0;
                r_cum[i] <= '0;
            end
        end else if (w_take) begin
            r_cnt <= n_cnt; r_crc <= n_crc; r_hcalc <= n_hcalc; r_gen <= n_gen;
            r_psz <= n_psz; r_pcrc <= n_pcrc; r_hcrc <= n_hcrc; r_pcalc <= n_pcalc;
            r_magic_ok <= n_magic_ok; r_ver <= n_ver; r_hsz <= n_hsz; r_exp <= n_exp;
            r_len <= n_len;
            r_cum <= n_cum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) r_out <= n_out;
    end

    `CFRC_ASSERT_NOW(a_status_only_done, i_clk, i_rst_n, r_out_valid && !r_out.done_res, r_out.status == cfrc_pkg::ST_OK)
    `CFRC_ASSERT_NOW(a_index_needs_tag, i_clk, i_rst_n, r_out_valid && !r_out.in_field, r_out.field_index == 3'd0)
    `CFRC_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, w_take && i_q_data.last_byte, r_cnt == 32'd0 && r_magic_ok)
endmodule
`default_nettype wire

[tb/sv/crc_framed_record_checker_tb.sv]
// Self-checking testbench for the streaming CRC-framed record checker.
`timescale 1ns / 1ps
`default_nettype none
module crc_framed_record_checker_tb;

    // Expected results, predicted from accepted bytes.
    class record_scoreboard;
        logic [15:0] limit_q [8];
        logic [31:0] n_bytes;
        logic [31:0] crc_acc;
        logic [31:0] hdr_crc_seen;
        bit          magic_good;
        logic [15:0] ver;
        logic [15:0] hsize;
        logic [31:0] gen;
        logic [31:0] psize;
        logic [31:0] pcrc_word;
        logic [31:0] hcrc_word;
        logic [63:0] expiry;
        logic [15:0] flen [8];
        logic [31:0] pcrc_seen;
        cfrc_pkg::t_out_item pending[$];
        int          n_fail;
        int          n_checked;
        int          n_records;
        int          n_ok;

        function new();
            for (int i = 0; i < 8; i++) limit_q[i] = cfrc_pkg::LIMIT_RESET;
            n_fail = 0;
            n_checked = 0;
            n_records = 0;
            n_ok = 0;
            clear_record();
        endfunction

        function void clear_record();
            n_bytes = 0;
            crc_acc = cfrc_pkg::CRC_INIT;
            hdr_crc_seen = 0;
            magic_good = 1;
            ver = 0;
            hsize = 0;
            gen = 0;
            psize = 0;
            pcrc_word = 0;
            hcrc_word = 0;
            expiry = 0;
            for (int i = 0; i < 8; i++) flen[i] = 0;
            pcrc_seen = 0;
        endfunction

        function logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
            logic [31:0] c;
            c = crc ^ {24'd0, b};
            for (int k = 0; k < 8; k++) c = (c >> 1) ^ (c[0] ? cfrc_pkg::CRC_POLY : 32'd0);
            return c;
        endfunction

        function logic [31:0] pay_hdr();
            return (ver == cfrc_pkg::VERSION_OLD) ? cfrc_pkg::PAY_HDR_V1
                                                  : cfrc_pkg::PAY_HDR_V2;
        endfunction

        function logic [3:0] verdict();
            logic [31:0] sum;
            logic [31:0] phs;
            sum = 0;
            if (n_bytes < cfrc_pkg::HDR_BYTES) return cfrc_pkg::ST_SHORT;
            if (!magic_good) return cfrc_pkg::ST_MAGIC;
            if (hsize != cfrc_pkg::HDR_BYTES[15:0]) return cfrc_pkg::ST_HDRSIZE;
            if (hdr_crc_seen != hcrc_word) return cfrc_pkg::ST_HDRCRC;
            if (ver != cfrc_pkg::VERSION_NEW && ver != cfrc_pkg::VERSION_OLD)
                return cfrc_pkg::ST_VERSION;
            phs = pay_hdr();
            if (psize < phs || psize > n_bytes - cfrc_pkg::HDR_BYTES)
                return cfrc_pkg::ST_PAYSIZE;
            if (pcrc_seen != pcrc_word) return cfrc_pkg::ST_PAYCRC;
            for (int i = 0; i < 8; i++) begin
                if (flen[i] >= limit_q[i]) return cfrc_pkg::ST_LENGTHS;
                sum += flen[i];
            end
            if (flen[0] == 0 || flen[1] == 0) return cfrc_pkg::ST_LENGTHS;
            if (sum != psize - phs) return cfrc_pkg::ST_LENGTHS;
            return cfrc_pkg::ST_OK;
        endfunction

        // Note one accepted byte and queue its result.
        function void note_byte(cfrc_pkg::t_in_item it);
            cfrc_pkg::t_out_item r;
            logic [7:0]  b;
            logic [31:0] n;
            logic [31:0] p;
            logic [31:0] q;
            logic [31:0] cum;
            logic [31:0] fi;
            b = it.data_byte;
            n = n_bytes;
            r = '0;
            r.byte_out = b;
            if (n != cfrc_pkg::COUNT_MAX) begin
                if (n < 4) begin
                    if (b != cfrc_pkg::MAGIC_WORD[31 - 8*n -: 8]) magic_good = 0;
                end else if (n < 6) ver = {ver[7:0], b};
                else if (n < 8) hsize = {hsize[7:0], b};
                else if (n < 12) gen = {gen[23:0], b};
                else if (n < 16) psize = {psize[23:0], b};
                else if (n < 20) pcrc_word = {pcrc_word[23:0], b};
                else if (n < 24) hcrc_word = {hcrc_word[23:0], b};
                if (n < 20) begin
                    crc_acc = crc_step(crc_acc, b);
                    if (n == cfrc_pkg::HDR_CRC_LAST) begin
                        hdr_crc_seen = ~crc_acc;
                        crc_acc = cfrc_pkg::CRC_INIT;
                        pcrc_seen = 0;
                    end
                end else if (n >= cfrc_pkg::HDR_BYTES) begin
                    p = n - cfrc_pkg::HDR_BYTES;
                    if (p < psize) begin
                        crc_acc = crc_step(crc_acc, b);
                        pcrc_seen = ~crc_acc;
                    end
                    if (p < 8) expiry = {expiry[55:0], b};
                    else if (p < cfrc_pkg::PAY_HDR_V2) begin
                        fi = (p - 8) >> 1;
                        if (ver != cfrc_pkg::VERSION_OLD || fi < 4)
                            flen[fi] = {flen[fi][7:0], b};
                    end
                    if (p >= pay_hdr() && p < psize) begin
                        q = p - pay_hdr();
                        cum = 0;
                        for (int i = 0; i < 8; i++) begin
                            cum += flen[i];
                            if (q < cum) begin
                                r.in_field = 1;
                                r.field_index = i[2:0];
                                break;
                            end
                        end
                    end
                end
                n_bytes = n + 1;
            end
            r.done_res = it.last_byte;
            if (it.last_byte) begin
                r.status = verdict();
                r.record_generation = gen;
                r.expires_at = expiry;
                n_records++;
                if (r.status == cfrc_pkg::ST_OK) n_ok++;
                clear_record();
            end
            pending.push_back(r);
        endfunction

        // Compare one accepted result against the oldest prediction.
        function void check_result(cfrc_pkg::t_out_item got);
            cfrc_pkg::t_out_item e;
            if (pending.size() == 0) begin
                $error("unexpected result %p", got);
                n_fail++;
                return;
            end
            e = pending.pop_front();
            n_checked++;
            if (got.byte_out != e.byte_out) begin
                $error("byte_out exp %0h got %0h", e.byte_out, got.byte_out); n_fail++;
            end
            if (got.in_field != e.in_field) begin
                $error("in_field exp %0d got %0d", e.in_field, got.in_field); n_fail++;
            end
            if (got.field_index != e.field_index) begin
                $error("field_index exp %0d got %0d", e.field_index, got.field_index);
                n_fail++;
            end
            if (got.done_res != e.done_res) begin
                $error("done_res exp %0d got %0d", e.done_res, got.done_res); n_fail++;
            end
            if (got.status != e.status) begin
                $error("status exp %0d got %0d", e.status, got.status); n_fail++;
            end
            if (got.record_generation != e.record_generation) begin
                $error("record_generation exp %0h got %0h", e.record_generation,
                       got.record_generation);
                n_fail++;
            end
            if (got.expires_at != e.expires_at) begin
                $error("expires_at exp %0h got %0h", e.expires_at, got.expires_at);
                n_fail++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    cfrc_pkg::t_in_item  in_item;
    logic        out_valid;
    logic        out_ready;
    cfrc_pkg::t_out_item out_item;
    logic        cfg_we;
    logic [3:0]  cfg_idx;
    logic [15:0] cfg_data;

    record_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int n_sent;

    crc_framed_record_checker u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_ready    (in_ready),
        .i_data     (in_item),
        .o_valid    (out_valid),
        .i_ready    (out_ready),
        .o_data     (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the handshake hangs.
    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    // Sample results at the edge; randomly hold off ready.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) sb.check_result(out_item);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Drive one byte, idling first as asked, and hold it until accepted.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        in_item  <= '{data_byte: b, last_byte: last};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_byte('{data_byte: b, last_byte: last});
        n_sent++;
    endtask

    // Send a byte array as one record; last byte carries the end marker.
    task automatic send_record(input logic [7:0] rec[$]);
        foreach (rec[i]) send_byte(rec[i], i == rec.size() - 1);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Present one write for a cycle; the caller drops the enable after the last one.
    task automatic write_limit(input int idx, input logic [15:0] val);
        cfg_we   <= 1;
        cfg_idx  <= idx[3:0];
        cfg_data <= val;
        @(posedge clk);
        sb.limit_q[idx] = val;
    endtask

    // Build a record; corrupt selects which check to break (0 or 5 keeps it well formed).
    task automatic build_record(output logic [7:0] rec[$], input logic [15:0] ver,
                                input int corrupt, input int max_len);
        logic [7:0]  pay[$];
        logic [15:0] lens[8];
        logic [31:0] crc;
        logic [31:0] hcrc;
        logic [31:0] gen;
        int          nf;
        nf = (ver == cfrc_pkg::VERSION_OLD) ? 4 : 8;
        pay = {};
        rec = {};
        for (int i = 0; i < 8; i++) pay.push_back(8'($urandom_range(255)));
        for (int i = 0; i < 8; i++) begin
            lens[i] = (i < nf) ? 16'($urandom_range(max_len)) : 16'd0;
            if (i < 2 && lens[i] == 0) lens[i] = 1;
            if (corrupt == 8 && i == 0 && $urandom_range(1)) lens[i] = 0;
        end
        for (int i = 0; i < nf; i++) begin
            pay.push_back(lens[i][15:8]);
            pay.push_back(lens[i][7:0]);
        end
        for (int i = 0; i < nf; i++)
            repeat (lens[i]) pay.push_back(8'($urandom_range(255)));
        if (corrupt == 8 && $urandom_range(1)) pay.push_back(8'($urandom_range(255)));
        crc = cfrc_pkg::CRC_INIT;
        foreach (pay[i]) crc = sb.crc_step(crc, pay[i]);
        crc = ~crc;
        if (pay.size() == 0) crc = 0;
        if (corrupt == 7) crc ^= 32'h1 << $urandom_range(31);
        gen = $urandom;
        rec = {cfrc_pkg::MAGIC_WORD[31:24], cfrc_pkg::MAGIC_WORD[23:16],
               cfrc_pkg::MAGIC_WORD[15:8], cfrc_pkg::MAGIC_WORD[7:0],
               ver[15:8], ver[7:0], 8'd0, 8'd24,
               gen[31:24], gen[23:16], gen[15:8], gen[7:0]};
        if (corrupt == 2) rec[$urandom_range(3)] ^= 8'h1 << $urandom_range(7);
        if (corrupt == 3) rec[7] = 8'($urandom_range(23));
        begin
            logic [31:0] ps;
            ps = 32'(pay.size());
            if (corrupt == 6) ps = ps + 1 + $urandom_range(3);
            rec.push_back(ps[31:24]); rec.push_back(ps[23:16]);
            rec.push_back(ps[15:8]);  rec.push_back(ps[7:0]);
        end
        rec.push_back(crc[31:24]); rec.push_back(crc[23:16]);
        rec.push_back(crc[15:8]);  rec.push_back(crc[7:0]);
        hcrc = cfrc_pkg::CRC_INIT;
        foreach (rec[i]) hcrc = sb.crc_step(hcrc, rec[i]);
        hcrc = ~hcrc;
        if (corrupt == 4) hcrc ^= 32'h1 << $urandom_range(31);
        rec.push_back(hcrc[31:24]); rec.push_back(hcrc[23:16]);
        rec.push_back(hcrc[15:8]);  rec.push_back(hcrc[7:0]);
        foreach (pay[i]) rec.push_back(pay[i]);
        // Trailing bytes beyond the payload, not covered or tagged.
        if ($urandom_range(5) == 0) repeat ($urandom_range(1, 3)) rec.push_back(8'($urandom));
        if (corrupt == 1) rec = rec[0:$urandom_range(22)];
    endtask

    task automatic random_phase(input int n_items);
        logic [7:0] rec[$];
        int         pick;
        int         target;
        target = n_sent + n_items;
        while (n_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                build_record(rec, ($urandom_range(1) ? cfrc_pkg::VERSION_NEW
                                                     : cfrc_pkg::VERSION_OLD),
                             0, 6);
            end else if (pick < 92) begin
                build_record(rec, cfrc_pkg::VERSION_NEW, $urandom_range(1, 8), 6);
            end else if (pick < 96) begin
                // Unknown version, layout of the newer format.
                build_record(rec, 16'($urandom_range(3, 65535)), 0, 4);
            end else begin
                rec = {};
                repeat ($urandom_range(1, 40)) rec.push_back(8'($urandom));
            end
            send_record(rec);
        end
    endtask

    initial begin
        logic [7:0] rec[$];
        sb = new();
        rst_n = 0;
        in_valid = 0;
        in_item = '0;
        out_ready = 0;
        cfg_we = 0;
        cfg_idx = '0;
        cfg_data = '0;
        n_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: reset limits, both versions, each failing check, extremes.
        build_record(rec, cfrc_pkg::VERSION_NEW, 0, 3); send_record(rec);
        build_record(rec, cfrc_pkg::VERSION_OLD, 0, 3); send_record(rec);
        for (int c = 1; c <= 8; c++) begin
            build_record(rec, cfrc_pkg::VERSION_NEW, c, 2);
            send_record(rec);
        end
        build_record(rec, 16'hFFFF, 0, 1); send_record(rec);
        send_byte(8'hFF, 1);
        send_byte(8'h00, 1);
        drain();

        // Tight limits: fields at or above the limit fail; a limit of 1 rejects any nonzero length.
        for (int i = 0; i < 8; i++) write_limit(i, (i == 7) ? 16'd1 : 16'd3);
        cfg_we <= 0;
        build_record(rec, cfrc_pkg::VERSION_OLD, 0, 4); send_record(rec);
        build_record(rec, cfrc_pkg::VERSION_NEW, 0, 4); send_record(rec);
        drain();

        for (int i = 0; i < 8; i++) write_limit(i, 16'hFFFF);
        cfg_we <= 0;
        send_idle_pct = 24;
        recv_idle_pct = 48;
        random_phase(260);
        drain();

        for (int i = 0; i < 8; i++) write_limit(i, 16'($urandom_range(2, 8)));
        cfg_we <= 0;
        send_idle_pct = 48;
        recv_idle_pct = 24;
        random_phase(260);
        drain();

        for (int i = 0; i < 8; i++) write_limit(i, 16'($urandom_range(1, 65535)));
        write_limit(0, 16'd256);
        write_limit(1, 16'd256);
        cfg_we <= 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(260);
        drain();

        $display("Covered %0d bytes in %0d records (%0d clean), %0d results checked.",
                 n_sent, sb.n_records, sb.n_ok, sb.n_checked);
        if (sb.n_fail == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
